// ----- hw/rtl/cpu_8bit_instruction_execute_unit_defines.svh -----
// assertion macros for the execute unit checker
// used by the bound port checker only
`ifndef CPU_8BIT_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
`define CPU_8BIT_INSTRUCTION_EXECUTE_UNIT_DEFINES_SVH
// property that holds outside reset
`define CEU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked during reset as well
`define CEU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- hw/rtl/ceu_pkg.sv -----
// shared types, constants and decode tables for the execute unit
// no dependencies
`timescale 1ns / 1ps
package ceu_pkg;

  typedef enum logic [1:0] {
    OP_EXEC = 2'd0, OP_NMI = 2'd1, OP_IRQ = 2'd2, OP_RESET = 2'd3
  } ev_op_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0, KIND_DONE = 2'd1, KIND_UNIMPL = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  opcode;
    logic [7:0]  operand;
    logic [15:0] address;
    logic [15:0] pc;
    logic [7:0]  pulled_first;
    logic [7:0]  pulled_second;
    logic [7:0]  pulled_third;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] next_pc;
    logic [3:0]  cycle_count;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  status_out;
    logic [7:0]  sp_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } regs_t;

  // one executed event: up to three writes and a completion
  typedef struct packed {
    logic [1:0]       nwr;
    logic [2:0][15:0] wr_addr;
    logic [2:0][7:0]  wr_data;
    logic [1:0]       kind;
    logic [15:0]      next_pc;
    logic [3:0]       cyc;
    regs_t            regs;
  } ev_res_t;

  localparam logic [7:0]  SP_RESET  = 8'hFD;
  localparam logic [7:0]  P_RESET   = 8'h24;
  localparam logic [7:0]  P_BRK     = 8'h30;
  localparam logic [7:0]  P_UNUSED  = 8'h20;
  localparam logic [7:0]  P_PULLMSK = 8'hCF;
  localparam logic [7:0]  STACK_HI  = 8'h01;
  localparam logic [7:0]  FL_C = 8'h01;
  localparam logic [7:0]  FL_Z = 8'h02;
  localparam logic [7:0]  FL_I = 8'h04;
  localparam logic [7:0]  FL_D = 8'h08;
  localparam logic [7:0]  FL_V = 8'h40;
  localparam logic [7:0]  FL_N = 8'h80;
  localparam logic [15:0] PAGE_MSK = 16'hFF00;
  localparam logic [7:0]  SIGN_BIT = 8'h80;

  // base cycle count per opcode, zero means unimplemented
  function automatic logic [3:0] cyc_lookup(input logic [7:0] opc);
    logic [3:0] c;
    c = 4'd0;
    case (opc)
      8'h00: c = 4'd7; 8'h01: c = 4'd6; 8'h05: c = 4'd3; 8'h06: c = 4'd5;
      8'h08: c = 4'd3; 8'h09: c = 4'd2; 8'h0A: c = 4'd2; 8'h0D: c = 4'd4;
      8'h0E: c = 4'd6;
      8'h10: c = 4'd2; 8'h11: c = 4'd5; 8'h15: c = 4'd4; 8'h16: c = 4'd6;
      8'h18: c = 4'd2; 8'h19: c = 4'd4; 8'h1D: c = 4'd4; 8'h1E: c = 4'd7;
      8'h20: c = 4'd6; 8'h21: c = 4'd6; 8'h24: c = 4'd3; 8'h25: c = 4'd3;
      8'h26: c = 4'd5; 8'h28: c = 4'd4; 8'h29: c = 4'd2; 8'h2A: c = 4'd2;
      8'h2C: c = 4'd4; 8'h2D: c = 4'd4; 8'h2E: c = 4'd6;
      8'h30: c = 4'd2; 8'h31: c = 4'd5; 8'h35: c = 4'd4; 8'h36: c = 4'd6;
      8'h38: c = 4'd2; 8'h39: c = 4'd4; 8'h3D: c = 4'd4; 8'h3E: c = 4'd7;
      8'h40: c = 4'd6; 8'h41: c = 4'd6; 8'h45: c = 4'd3; 8'h46: c = 4'd5;
      8'h48: c = 4'd3; 8'h49: c = 4'd2; 8'h4A: c = 4'd2; 8'h4C: c = 4'd3;
      8'h4D: c = 4'd4; 8'h4E: c = 4'd6;
      8'h50: c = 4'd2; 8'h51: c = 4'd5; 8'h55: c = 4'd4; 8'h56: c = 4'd6;
      8'h58: c = 4'd2; 8'h59: c = 4'd4; 8'h5D: c = 4'd4; 8'h5E: c = 4'd7;
      8'h60: c = 4'd6; 8'h61: c = 4'd6; 8'h65: c = 4'd3; 8'h66: c = 4'd5;
      8'h68: c = 4'd4; 8'h69: c = 4'd2; 8'h6A: c = 4'd2; 8'h6C: c = 4'd5;
      8'h6D: c = 4'd4; 8'h6E: c = 4'd6;
      8'h70: c = 4'd2; 8'h71: c = 4'd5; 8'h75: c = 4'd4; 8'h76: c = 4'd6;
      8'h78: c = 4'd2; 8'h79: c = 4'd4; 8'h7D: c = 4'd4; 8'h7E: c = 4'd7;
      8'h81: c = 4'd6; 8'h84: c = 4'd3; 8'h85: c = 4'd3; 8'h86: c = 4'd3;
      8'h88: c = 4'd2; 8'h8A: c = 4'd2; 8'h8C: c = 4'd4; 8'h8D: c = 4'd4;
      8'h8E: c = 4'd4;
      8'h90: c = 4'd2; 8'h91: c = 4'd6; 8'h94: c = 4'd4; 8'h95: c = 4'd4;
      8'h96: c = 4'd4; 8'h98: c = 4'd2; 8'h99: c = 4'd5; 8'h9A: c = 4'd2;
      8'h9D: c = 4'd5;
      8'hA0: c = 4'd2; 8'hA1: c = 4'd6; 8'hA2: c = 4'd2; 8'hA4: c = 4'd3;
      8'hA5: c = 4'd3; 8'hA6: c = 4'd3; 8'hA8: c = 4'd2; 8'hA9: c = 4'd2;
      8'hAA: c = 4'd2; 8'hAC: c = 4'd4; 8'hAD: c = 4'd4; 8'hAE: c = 4'd4;
      8'hB0: c = 4'd2; 8'hB1: c = 4'd5; 8'hB4: c = 4'd4; 8'hB5: c = 4'd4;
      8'hB6: c = 4'd4; 8'hB8: c = 4'd2; 8'hB9: c = 4'd4; 8'hBA: c = 4'd2;
      8'hBC: c = 4'd4; 8'hBD: c = 4'd4; 8'hBE: c = 4'd4;
      8'hC0: c = 4'd2; 8'hC1: c = 4'd6; 8'hC4: c = 4'd3; 8'hC5: c = 4'd3;
      8'hC6: c = 4'd5; 8'hC8: c = 4'd2; 8'hC9: c = 4'd2; 8'hCA: c = 4'd2;
      8'hCC: c = 4'd4; 8'hCD: c = 4'd4; 8'hCE: c = 4'd6;
      8'hD0: c = 4'd2; 8'hD1: c = 4'd5; 8'hD5: c = 4'd4; 8'hD6: c = 4'd6;
      8'hD8: c = 4'd2; 8'hD9: c = 4'd4; 8'hDD: c = 4'd4; 8'hDE: c = 4'd7;
      8'hE0: c = 4'd2; 8'hE1: c = 4'd6; 8'hE4: c = 4'd3; 8'hE5: c = 4'd3;
      8'hE6: c = 4'd5; 8'hE8: c = 4'd2; 8'hE9: c = 4'd2; 8'hEA: c = 4'd2;
      8'hEC: c = 4'd4; 8'hED: c = 4'd4; 8'hEE: c = 4'd6;
      8'hF0: c = 4'd2; 8'hF1: c = 4'd5; 8'hF5: c = 4'd4; 8'hF6: c = 4'd6;
      8'hF8: c = 4'd2; 8'hF9: c = 4'd4; 8'hFD: c = 4'd4; 8'hFE: c = 4'd7;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/ceu_exec.sv -----
// combinational execute of one event against the register file
// depends on ceu_pkg
`timescale 1ns / 1ps
module ceu_exec import ceu_pkg::*; (
  input  in_item_t ev,
  input  regs_t    cur,
  output ev_res_t  res
);

  logic [7:0]  a, x, y, sp, p, v, opc, sh_r, sel_flag;
  logic [8:0]  sum, cmp_d;
  logic [15:0] npc, ret, tgt, off;
  logic [3:0]  cyc;
  logic [1:0]  nwr;
  logic [2:0][15:0] wa;
  logic [2:0][7:0]  wd;
  logic        c_in, flag, do_cmp, do_add, push1;
  logic [7:0]  cmp_r, add_v;

  // nz flag update helper
  function automatic logic [7:0] set_nz(input logic [7:0] pf, input logic [7:0] r);
    logic [7:0] q;
    q = pf & ~(FL_N | FL_Z);
    if (r == 8'd0) q = q | FL_Z;
    if (r[7]) q = q | FL_N;
    return q;
  endfunction

  always_comb begin
    a = cur.a; x = cur.x; y = cur.y; sp = cur.sp; p = cur.p;
    v = ev.operand; opc = ev.opcode;
    c_in = cur.p[0];
    npc = ev.pc; cyc = cyc_lookup(opc);
    nwr = 2'd0; wa = '0; wd = '0;
    ret = 16'd0; tgt = 16'd0; off = 16'd0; sum = 9'd0; cmp_d = 9'd0;
    sh_r = 8'd0; sel_flag = 8'd0; flag = 1'b0;
    do_cmp = 1'b0; do_add = 1'b0; cmp_r = 8'd0; add_v = 8'd0; push1 = 1'b0;
    res.kind = KIND_DONE;
    unique case (ev.op)
      OP_RESET: begin
        a = 8'd0; x = 8'd0; y = 8'd0; sp = SP_RESET; p = P_RESET;
        npc = ev.address; cyc = 4'd8;
      end
      OP_NMI, OP_IRQ: begin
        if (ev.op == OP_IRQ && (cur.p & FL_I) != 8'd0) begin
          cyc = 4'd0;
        end else begin
          nwr = 2'd3;
          wa[0] = {STACK_HI, cur.sp};
          wd[0] = ev.pc[15:8];
          wa[1] = {STACK_HI, cur.sp - 8'd1};
          wd[1] = ev.pc[7:0];
          wa[2] = {STACK_HI, cur.sp - 8'd2};
          wd[2] = cur.p | P_UNUSED;
          sp = cur.sp - 8'd3; p = cur.p | FL_I;
          npc = ev.address;
          cyc = (ev.op == OP_NMI) ? 4'd8 : 4'd7;
        end
      end
      default: begin
        if (cyc == 4'd0) begin
          res.kind = KIND_UNIMPL; cyc = 4'd2;
        end else if (opc[1:0] == 2'b01) begin
          // group one alu
          case (opc[7:5])
            3'd0: begin a = cur.a | v; p = set_nz(p, a); end
            3'd1: begin a = cur.a & v; p = set_nz(p, a); end
            3'd2: begin a = cur.a ^ v; p = set_nz(p, a); end
            3'd3: begin do_add = 1'b1; add_v = v; end
            3'd4: begin nwr = 2'd1; wa[0] = ev.address; wd[0] = cur.a; end
            3'd5: begin a = v; p = set_nz(p, a); end
            3'd6: begin do_cmp = 1'b1; cmp_r = cur.a; end
            default: begin do_add = 1'b1; add_v = ~v; end
          endcase
        end else if (opc[4:0] == 5'h10) begin
          // conditional branch
          case (opc[7:6])
            2'd0: sel_flag = FL_N;
            2'd1: sel_flag = FL_V;
            2'd2: sel_flag = FL_C;
            default: sel_flag = FL_Z;
          endcase
          flag = (cur.p & sel_flag) != 8'd0;
          if (flag == opc[5]) begin
            off = {{8{v[7]}}, v};
            tgt = ev.pc + off;
            cyc = cyc + 4'd1;
            if ((tgt & PAGE_MSK) != (ev.pc & PAGE_MSK)) cyc = cyc + 4'd1;
            npc = tgt;
          end
        end else begin
          case (opc)
            8'h0A, 8'h2A, 8'h4A, 8'h6A,
            8'h06, 8'h16, 8'h0E, 8'h1E, 8'h26, 8'h36, 8'h2E, 8'h3E,
            8'h46, 8'h56, 8'h4E, 8'h5E, 8'h66, 8'h76, 8'h6E, 8'h7E: begin
              sh_r = (opc[3:0] == 4'hA) ? cur.a : v;
              case (opc[6:5])
                2'd0: begin p[0] = sh_r[7]; sh_r = {sh_r[6:0], 1'b0}; end
                2'd1: begin p[0] = sh_r[7]; sh_r = {sh_r[6:0], c_in}; end
                2'd2: begin p[0] = sh_r[0]; sh_r = {1'b0, sh_r[7:1]}; end
                default: begin p[0] = sh_r[0]; sh_r = {c_in, sh_r[7:1]}; end
              endcase
              p = set_nz(p, sh_r);
              if (opc[3:0] == 4'hA) a = sh_r;
              else begin nwr = 2'd1; wa[0] = ev.address; wd[0] = sh_r; end
            end
            8'hC6, 8'hD6, 8'hCE, 8'hDE: begin
              nwr = 2'd1; wa[0] = ev.address; wd[0] = v - 8'd1; p = set_nz(p, wd[0]);
            end
            8'hE6, 8'hF6, 8'hEE, 8'hFE: begin
              nwr = 2'd1; wa[0] = ev.address; wd[0] = v + 8'd1; p = set_nz(p, wd[0]);
            end
            8'h24, 8'h2C: begin
              p = (cur.p & ~(FL_Z | FL_V | FL_N)) | (v & (FL_V | FL_N));
              if ((cur.a & v) == 8'd0) p = p | FL_Z;
            end
            8'hE0, 8'hE4, 8'hEC: begin do_cmp = 1'b1; cmp_r = cur.x; end
            8'hC0, 8'hC4, 8'hCC: begin do_cmp = 1'b1; cmp_r = cur.y; end
            8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: begin x = v; p = set_nz(p, x); end
            8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: begin y = v; p = set_nz(p, y); end
            8'h86, 8'h96, 8'h8E: begin nwr = 2'd1; wa[0] = ev.address; wd[0] = cur.x; end
            8'h84, 8'h94, 8'h8C: begin nwr = 2'd1; wa[0] = ev.address; wd[0] = cur.y; end
            8'h00: begin
              ret = ev.pc + 16'd1;
              nwr = 2'd3;
              wa[0] = {STACK_HI, cur.sp};        wd[0] = ret[15:8];
              wa[1] = {STACK_HI, cur.sp - 8'd1}; wd[1] = ret[7:0];
              wa[2] = {STACK_HI, cur.sp - 8'd2}; wd[2] = cur.p | P_BRK;
              sp = cur.sp - 8'd3; p = cur.p | FL_I; npc = ev.address;
            end
            8'h20: begin
              ret = ev.pc - 16'd1;
              nwr = 2'd2;
              wa[0] = {STACK_HI, cur.sp};        wd[0] = ret[15:8];
              wa[1] = {STACK_HI, cur.sp - 8'd1}; wd[1] = ret[7:0];
              sp = cur.sp - 8'd2; npc = ev.address;
            end
            8'h4C, 8'h6C: npc = ev.address;
            8'h40: begin
              p = ev.pulled_first & P_PULLMSK;
              npc = {ev.pulled_third, ev.pulled_second};
              sp = cur.sp + 8'd3;
            end
            8'h60: begin
              npc = {ev.pulled_second, ev.pulled_first} + 16'd1;
              sp = cur.sp + 8'd2;
            end
            8'h48: begin push1 = 1'b1; wd[0] = cur.a; end
            8'h08: begin push1 = 1'b1; wd[0] = cur.p | P_BRK; end
            8'h68: begin sp = cur.sp + 8'd1; a = ev.pulled_first; p = set_nz(p, a); end
            8'h28: begin sp = cur.sp + 8'd1; p = ev.pulled_first & P_PULLMSK; end
            8'h18: p = cur.p & ~FL_C;
            8'h38: p = cur.p | FL_C;
            8'h58: p = cur.p & ~FL_I;
            8'h78: p = cur.p | FL_I;
            8'hB8: p = cur.p & ~FL_V;
            8'hD8: p = cur.p & ~FL_D;
            8'hF8: p = cur.p | FL_D;
            8'hCA: begin x = cur.x - 8'd1; p = set_nz(p, x); end
            8'h88: begin y = cur.y - 8'd1; p = set_nz(p, y); end
            8'hE8: begin x = cur.x + 8'd1; p = set_nz(p, x); end
            8'hC8: begin y = cur.y + 8'd1; p = set_nz(p, y); end
            8'hAA: begin x = cur.a; p = set_nz(p, x); end
            8'hA8: begin y = cur.a; p = set_nz(p, y); end
            8'hBA: begin x = cur.sp; p = set_nz(p, x); end
            8'h8A: begin a = cur.x; p = set_nz(p, a); end
            8'h9A: sp = cur.x;
            8'h98: begin a = cur.y; p = set_nz(p, a); end
            default: ;
          endcase
        end
        // single stack push
        if (push1) begin
          nwr = 2'd1; wa[0] = {STACK_HI, cur.sp}; sp = cur.sp - 8'd1;
        end
        // add with carry, subtract via inverted operand
        if (do_add) begin
          sum = {1'b0, cur.a} + {1'b0, add_v} + {8'd0, c_in};
          p[0] = sum[8];
          p[6] = ~(cur.a[7] ^ add_v[7]) & (cur.a[7] ^ sum[7]);
          a = sum[7:0];
          p = set_nz(p, a);
        end
        // compare
        if (do_cmp) begin
          cmp_d = {1'b0, cmp_r} - {1'b0, v};
          p[0] = ~cmp_d[8];
          p = set_nz(p, cmp_d[7:0]);
        end
      end
    endcase
    res.nwr = nwr; res.wr_addr = wa; res.wr_data = wd;
    res.next_pc = npc; res.cyc = cyc;
    res.regs = '{a: a, x: x, y: y, sp: sp, p: p};
  end

endmodule

// ----- hw/rtl/cpu_8bit_instruction_execute_unit.sv -----
// execute unit: one event per input transfer, results drained from a registered buffer
// first result offered in the cycle after the input transfer; an event emits 1 to 4 results
// throughput: one result per cycle while out_stall is low; a new event is taken only when
//   the buffer is empty or the final result of the buffered event leaves
// reset: A, X, Y cleared, SP 0xFD, P 0x24, output buffer empty
`timescale 1ns / 1ps
module cpu_8bit_instruction_execute_unit import ceu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  regs_t   regs_r, regs_nxt;
  ev_res_t buf_r, buf_nxt, ex_res;
  logic    busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic    in_xfer, out_xfer, is_last;

  ceu_exec u_exec (.ev(in_data), .cur(regs_r), .res(ex_res));

  // result selection from buffer
  assign is_last = (idx_r == buf_r.nwr);
  always_comb begin
    out_data = '0;
    if (is_last) begin
      out_data.kind = buf_r.kind;
      out_data.next_pc = buf_r.next_pc;
      out_data.cycle_count = buf_r.cyc;
      out_data.acc_out = buf_r.regs.a;
      out_data.x_out = buf_r.regs.x;
      out_data.y_out = buf_r.regs.y;
      out_data.status_out = buf_r.regs.p;
      out_data.sp_out = buf_r.regs.sp;
      out_data.last = 1'b1;
    end else begin
      out_data.kind = KIND_WRITE;
      out_data.write_address = buf_r.wr_addr[idx_r];
      out_data.write_data = buf_r.wr_data[idx_r];
    end
  end

  assign out_valid = busy_r;
  assign out_xfer = busy_r && !out_stall;
  // accept when buffer empty or its final result leaves now
  assign in_stall = busy_r && !(out_xfer && is_last);
  assign in_xfer = in_valid && !in_stall;

  // buffer and register file control
  always_comb begin
    busy_nxt = busy_r; idx_nxt = idx_r; buf_nxt = buf_r; regs_nxt = regs_r;
    if (out_xfer) begin
      if (is_last) busy_nxt = 1'b0;
      else idx_nxt = idx_r + 2'd1;
    end
    if (in_xfer) begin
      busy_nxt = 1'b1; idx_nxt = 2'd0; buf_nxt = ex_res; regs_nxt = ex_res.regs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; idx_r <= 2'd0;
      regs_r <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: SP_RESET, p: P_RESET};
    end else begin
      busy_r <= busy_nxt; idx_r <= idx_nxt; regs_r <= regs_nxt;
    end
    buf_r <= buf_nxt;
  end

endmodule

// ----- hw/rtl/ceu_checker.sv -----
// port checker for the execute unit, bound to the top level
// depends on ceu_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "cpu_8bit_instruction_execute_unit_defines.svh"
module ceu_checker import ceu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);
  `CEU_ASSERT_RST(a_no_out_after_reset, $past(!rst_n) |-> !out_valid, "result valid after reset")
  `CEU_ASSERT(a_accept_shows_result, (in_valid && !in_stall) |=> out_valid, "transfer without result")
  `CEU_ASSERT(a_stall_only_busy, in_stall |-> out_valid, "stall with empty buffer")
  `CEU_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "stalled result changed")
endmodule

bind cpu_8bit_instruction_execute_unit ceu_checker u_ceu_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ----- dv/tb_cpu_8bit_instruction_execute_unit.sv -----
// self-checking testbench for the 8-bit cpu execute unit
// depends on ceu_pkg and cpu_8bit_instruction_execute_unit
`timescale 1ns / 1ps
module tb_cpu_8bit_instruction_execute_unit;
  import ceu_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  cpu_8bit_instruction_execute_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // cpu register copy used by the predictor
  logic [7:0] cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
  out_item_t  result_q[$];
  bit         failed;
  int         send_idle_pct;
  int         recv_stall_pct;
  bit         hold_off;
  int         quiet_cycles;

  // directed rows, with results typed in where obvious
  typedef struct {
    in_item_t  item;
    bit        has_done;
    out_item_t done;
  } row_t;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void cpu_reset();
    cpu_a = 8'h00;
    cpu_x = 8'h00;
    cpu_y = 8'h00;
    cpu_sp = SP_RESET;
    cpu_p = P_RESET;
  endfunction

  function automatic void set_flag(input logic [7:0] m, input bit on);
    if (on) cpu_p = cpu_p | m;
    else cpu_p = cpu_p & ~m;
  endfunction

  function automatic logic [7:0] set_nz(input logic [7:0] v);
    set_flag(FL_Z, v == 8'h00);
    set_flag(FL_N, v[7]);
    return v;
  endfunction

  function automatic void add_with_carry(input logic [7:0] v);
    logic [8:0] s;
    s = {1'b0, cpu_a} + {1'b0, v} + {8'h00, cpu_p[0]};
    set_flag(FL_C, s[8]);
    set_flag(FL_V, (~(cpu_a ^ v) & (cpu_a ^ s[7:0]) & SIGN_BIT) != 8'h00);
    cpu_a = set_nz(s[7:0]);
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] v);
    logic [7:0] d;
    set_flag(FL_C, r >= v);
    d = r - v;
    void'(set_nz(d));
  endfunction

  function automatic logic [7:0] shift_rotate(input logic [1:0] which, input logic [7:0] v);
    logic       c;
    logic [7:0] r;
    c = cpu_p[0];
    case (which)
      2'd0: begin
        set_flag(FL_C, v[7]);
        r = {v[6:0], 1'b0};
      end
      2'd1: begin
        set_flag(FL_C, v[7]);
        r = {v[6:0], c};
      end
      2'd2: begin
        set_flag(FL_C, v[0]);
        r = {1'b0, v[7:1]};
      end
      default: begin
        set_flag(FL_C, v[0]);
        r = {c, v[7:1]};
      end
    endcase
    return set_nz(r);
  endfunction

  function automatic void queue_write(input logic [15:0] a, input logic [7:0] d);
    out_item_t o;
    o = '0;
    o.kind = KIND_WRITE;
    o.write_address = a;
    o.write_data = d;
    result_q.push_back(o);
  endfunction

  function automatic void stack_push(input logic [7:0] d);
    queue_write({STACK_HI, cpu_sp}, d);
    cpu_sp = cpu_sp - 8'd1;
  endfunction

  function automatic void queue_done(input res_kind_t k, input logic [15:0] npc,
                                     input logic [3:0] cyc);
    out_item_t o;
    o = '0;
    o.kind = k;
    o.next_pc = npc;
    o.cycle_count = cyc;
    o.acc_out = cpu_a;
    o.x_out = cpu_x;
    o.y_out = cpu_y;
    o.status_out = cpu_p;
    o.sp_out = cpu_sp;
    o.last = 1'b1;
    result_q.push_back(o);
  endfunction

  // predict the results of one event and update the register copy
  function automatic void predict_event(input in_item_t it);
    logic [3:0]  cyc;
    logic [15:0] npc, tgt, ret;
    logic [7:0]  opc, v, sel;
    opc = it.opcode;
    v = it.operand;
    if (it.op == OP_RESET) begin
      cpu_reset();
      queue_done(KIND_DONE, it.address, 4'd8);
    end else if (it.op == OP_NMI || it.op == OP_IRQ) begin
      if (it.op == OP_IRQ && (cpu_p & FL_I) != 8'h00) begin
        queue_done(KIND_DONE, it.pc, 4'd0);
      end else begin
        stack_push(it.pc[15:8]);
        stack_push(it.pc[7:0]);
        stack_push(cpu_p | P_UNUSED);
        set_flag(FL_I, 1'b1);
        queue_done(KIND_DONE, it.address, (it.op == OP_NMI) ? 4'd8 : 4'd7);
      end
    end else begin
      cyc = cyc_lookup(opc);
      if (cyc == 4'd0) begin
        queue_done(KIND_UNIMPL, it.pc, 4'd2);
      end else begin
        npc = it.pc;
        if (opc[1:0] == 2'b01) begin
          case (opc[7:5])
            3'd0: cpu_a = set_nz(cpu_a | v);
            3'd1: cpu_a = set_nz(cpu_a & v);
            3'd2: cpu_a = set_nz(cpu_a ^ v);
            3'd3: add_with_carry(v);
            3'd4: queue_write(it.address, cpu_a);
            3'd5: cpu_a = set_nz(v);
            3'd6: compare_reg(cpu_a, v);
            default: add_with_carry(~v);
          endcase
        end else if (opc[4:0] == 5'h10) begin
          case (opc[7:6])
            2'd0: sel = FL_N;
            2'd1: sel = FL_V;
            2'd2: sel = FL_C;
            default: sel = FL_Z;
          endcase
          if (((cpu_p & sel) != 8'h00) == opc[5]) begin
            tgt = it.pc + {{8{v[7]}}, v};
            cyc = cyc + 4'd1;
            if ((tgt & PAGE_MSK) != (it.pc & PAGE_MSK)) cyc = cyc + 4'd1;
            npc = tgt;
          end
        end else begin
          case (opc)
            8'h0A, 8'h2A, 8'h4A, 8'h6A: cpu_a = shift_rotate(opc[6:5], cpu_a);
            8'h06, 8'h16, 8'h0E, 8'h1E, 8'h26, 8'h36, 8'h2E, 8'h3E,
            8'h46, 8'h56, 8'h4E, 8'h5E, 8'h66, 8'h76, 8'h6E, 8'h7E:
              queue_write(it.address, shift_rotate(opc[6:5], v));
            8'hC6, 8'hD6, 8'hCE, 8'hDE: queue_write(it.address, set_nz(v - 8'd1));
            8'hE6, 8'hF6, 8'hEE, 8'hFE: queue_write(it.address, set_nz(v + 8'd1));
            8'h24, 8'h2C: begin
              set_flag(FL_Z, (cpu_a & v) == 8'h00);
              set_flag(FL_V, v[6]);
              set_flag(FL_N, v[7]);
            end
            8'hE0, 8'hE4, 8'hEC: compare_reg(cpu_x, v);
            8'hC0, 8'hC4, 8'hCC: compare_reg(cpu_y, v);
            8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: cpu_x = set_nz(v);
            8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: cpu_y = set_nz(v);
            8'h86, 8'h96, 8'h8E: queue_write(it.address, cpu_x);
            8'h84, 8'h94, 8'h8C: queue_write(it.address, cpu_y);
            8'h00: begin
              ret = it.pc + 16'd1;
              stack_push(ret[15:8]);
              stack_push(ret[7:0]);
              stack_push(cpu_p | P_BRK);
              set_flag(FL_I, 1'b1);
              npc = it.address;
            end
            8'h20: begin
              ret = it.pc - 16'd1;
              stack_push(ret[15:8]);
              stack_push(ret[7:0]);
              npc = it.address;
            end
            8'h4C, 8'h6C: npc = it.address;
            8'h40: begin
              cpu_p = it.pulled_first & P_PULLMSK;
              npc = {it.pulled_third, it.pulled_second};
              cpu_sp = cpu_sp + 8'd3;
            end
            8'h60: begin
              npc = {it.pulled_second, it.pulled_first} + 16'd1;
              cpu_sp = cpu_sp + 8'd2;
            end
            8'h48: stack_push(cpu_a);
            8'h08: stack_push(cpu_p | P_BRK);
            8'h68: begin
              cpu_sp = cpu_sp + 8'd1;
              cpu_a = set_nz(it.pulled_first);
            end
            8'h28: begin
              cpu_sp = cpu_sp + 8'd1;
              cpu_p = it.pulled_first & P_PULLMSK;
            end
            8'h18: set_flag(FL_C, 1'b0);
            8'h38: set_flag(FL_C, 1'b1);
            8'h58: set_flag(FL_I, 1'b0);
            8'h78: set_flag(FL_I, 1'b1);
            8'hB8: set_flag(FL_V, 1'b0);
            8'hD8: set_flag(FL_D, 1'b0);
            8'hF8: set_flag(FL_D, 1'b1);
            8'hCA: cpu_x = set_nz(cpu_x - 8'd1);
            8'h88: cpu_y = set_nz(cpu_y - 8'd1);
            8'hE8: cpu_x = set_nz(cpu_x + 8'd1);
            8'hC8: cpu_y = set_nz(cpu_y + 8'd1);
            8'hAA: cpu_x = set_nz(cpu_a);
            8'hA8: cpu_y = set_nz(cpu_a);
            8'hBA: cpu_x = set_nz(cpu_sp);
            8'h8A: cpu_a = set_nz(cpu_x);
            8'h9A: cpu_sp = cpu_x;
            8'h98: cpu_a = set_nz(cpu_y);
            default: ;
          endcase
        end
        queue_done(KIND_DONE, npc, cyc);
      end
    end
  endfunction

  function automatic in_item_t make_event(input logic [1:0] op, input logic [7:0] opc,
                                          input logic [7:0] v, input logic [15:0] a,
                                          input logic [15:0] pc);
    in_item_t it;
    it.op = op;
    it.opcode = opc;
    it.operand = v;
    it.address = a;
    it.pc = pc;
    it.pulled_first = 8'($urandom);
    it.pulled_second = 8'($urandom);
    it.pulled_third = 8'($urandom);
    return it;
  endfunction

  // random event, mostly implemented instructions
  function automatic in_item_t random_event();
    in_item_t   it;
    logic [7:0] opc;
    int         r;
    r = $urandom_range(0, 99);
    opc = 8'($urandom);
    if (r >= 12) begin
      while (cyc_lookup(opc) == 4'd0) opc = 8'($urandom);
    end
    it = make_event(OP_EXEC, opc, 8'($urandom), 16'($urandom), 16'($urandom));
    if (r < 3) it.op = OP_RESET;
    else if (r < 6) it.op = OP_NMI;
    else if (r < 10) it.op = OP_IRQ;
    if ($urandom_range(0, 9) == 0) it.operand = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
    return it;
  endfunction

  // one input transfer, predicting on acceptance; valid stays up until idling
  task automatic send_event(input in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_event(it);
    @(negedge clk);
  endtask

  // result check against the oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("unexpected result transfer %h", out_data);
        failed = 1'b1;
      end else begin
        e = result_q.pop_front();
        if (out_data.kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_data.kind); failed = 1'b1;
        end
        if (out_data.write_address !== e.write_address) begin
          $error("write_address exp %h got %h", e.write_address, out_data.write_address);
          failed = 1'b1;
        end
        if (out_data.write_data !== e.write_data) begin
          $error("write_data exp %h got %h", e.write_data, out_data.write_data); failed = 1'b1;
        end
        if (out_data.next_pc !== e.next_pc) begin
          $error("next_pc exp %h got %h", e.next_pc, out_data.next_pc); failed = 1'b1;
        end
        if (out_data.cycle_count !== e.cycle_count) begin
          $error("cycle_count exp %0d got %0d", e.cycle_count, out_data.cycle_count);
          failed = 1'b1;
        end
        if (out_data.acc_out !== e.acc_out) begin
          $error("acc_out exp %h got %h", e.acc_out, out_data.acc_out); failed = 1'b1;
        end
        if (out_data.x_out !== e.x_out) begin
          $error("x_out exp %h got %h", e.x_out, out_data.x_out); failed = 1'b1;
        end
        if (out_data.y_out !== e.y_out) begin
          $error("y_out exp %h got %h", e.y_out, out_data.y_out); failed = 1'b1;
        end
        if (out_data.status_out !== e.status_out) begin
          $error("status_out exp %h got %h", e.status_out, out_data.status_out);
          failed = 1'b1;
        end
        if (out_data.sp_out !== e.sp_out) begin
          $error("sp_out exp %h got %h", e.sp_out, out_data.sp_out); failed = 1'b1;
        end
        if (out_data.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_data.last); failed = 1'b1;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int n;
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off && !held) begin
        out_stall <= 1'b1;
        for (n = 0; n < 60; n++) @(negedge clk);
        held = 1'b1;
      end
      out_stall <= (recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    row_t      rows[$];
    row_t      rw;
    out_item_t d;
    int        i, ph;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    cpu_reset();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset event gives fixed registers
    d = '0;
    d.kind = KIND_DONE; d.next_pc = 16'hFFFC; d.cycle_count = 4'd8;
    d.status_out = P_RESET; d.sp_out = SP_RESET; d.last = 1'b1;
    rw.item = make_event(OP_RESET, 8'h00, 8'h00, 16'hFFFC, 16'h0000);
    rw.has_done = 1'b1; rw.done = d; rows.push_back(rw);
    // unimplemented opcode leaves state alone
    d.kind = KIND_UNIMPL; d.next_pc = 16'hFFFF; d.cycle_count = 4'd2;
    rw.item = make_event(OP_EXEC, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    rw.done = d; rows.push_back(rw);
    // irq while I is set after reset: no change
    d.kind = KIND_DONE; d.next_pc = 16'h1234; d.cycle_count = 4'd0;
    rw.item = make_event(OP_IRQ, 8'h00, 8'h00, 16'hFFFE, 16'h1234);
    rw.done = d; rows.push_back(rw);
    rw.has_done = 1'b0;
    rw.item = make_event(OP_EXEC, 8'hA9, 8'h80, 16'h0000, 16'h0200); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'h69, 8'h80, 16'h0000, 16'h0202); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'hE9, 8'hFF, 16'h0000, 16'h0204); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'h85, 8'h00, 16'hFFFF, 16'h0206); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'h58, 8'h00, 16'h0000, 16'h0207); rows.push_back(rw);
    rw.item = make_event(OP_IRQ, 8'h00, 8'h00, 16'hFFFE, 16'h0208); rows.push_back(rw);
    rw.item = make_event(OP_NMI, 8'h00, 8'h00, 16'hFFFA, 16'hFFFF); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'h00, 8'h00, 16'hFFFE, 16'hFFFF); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'h40, 8'h00, 16'h0000, 16'h0300); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'h20, 8'h00, 16'h8000, 16'h0000); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'h60, 8'h00, 16'h0000, 16'h8000); rows.push_back(rw);
    // branches: bne, beq forward, beq backward across a page; Z comes from the random rti pull
    rw.item = make_event(OP_EXEC, 8'hD0, 8'h7F, 16'h0000, 16'h10F0); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'hF0, 8'h02, 16'h0000, 16'h1010); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'hF0, 8'h80, 16'h0000, 16'h1010); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'h28, 8'hFF, 16'h0000, 16'h1100); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'h08, 8'h00, 16'h0000, 16'h1101); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'h9A, 8'h00, 16'h0000, 16'h1102); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'h48, 8'h00, 16'h0000, 16'h1103); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'h7E, 8'h01, 16'h4000, 16'h1104); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'hDE, 8'h00, 16'h4001, 16'h1107); rows.push_back(rw);
    rw.item = make_event(OP_EXEC, 8'h2C, 8'hC0, 16'h4002, 16'h110A); rows.push_back(rw);

    for (i = 0; i < rows.size(); i++) begin
      send_event(rows[i].item);
      if (rows[i].has_done) result_q[result_q.size() - 1] = rows[i].done;
    end

    // random phases with different idle patterns
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 88; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 88; end
        3: begin send_idle_pct = 9; recv_stall_pct = 9; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b1; end
      endcase
      for (i = 0; i < 100; i++) send_event(random_event());
    end
    in_valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (!failed) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
